// ===== rtl/pcd_pkg.sv =====
// Package for the tree code decoder: sizes, register map and controller/datapath signal groups.
`default_nettype none

package pcd_pkg;

  // Largest tree the block decodes
  localparam int MAX_NODES = 64;

  // Fixed field widths
  localparam int NODE_W  = 7;
  localparam int CHILD_W = 6;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // Derived storage sizes
  localparam int IDX_W      = $clog2(MAX_NODES);
  localparam int CODE_DEPTH = MAX_NODES - 2;
  localparam int CODE_AW    = (CODE_DEPTH > 1) ? $clog2(CODE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(CODE_DEPTH + 1);

  localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(MAX_NODES);
  localparam logic [NODE_W-1:0] NODE_MIN = NODE_W'(2);

  // Register index of node_count (word address bits of paddr)
  localparam logic [ADDR_W-3:0] REG_NODE_COUNT = '0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic seq_clear;
    logic load_item;
    logic deg_inc;
    logic dec_init;
    logic code_rd;
    logic scan_rd;
    logic scan_step;
    logic leaf_set;
    logic assign_leaf;
    logic par_update;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic single_load;
  } pcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic two_node;
    logic code_flag;
    logic code_ok;
    logic seq_last;
    logic seq_full;
    logic range_err;
    logic leaf_none;
    logic ptr_past;
    logic deg_one;
    logic dec_last;
    logic emit_last;
    logic out_free;
  } pcd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pcd_in_if.sv =====
// Input channel: one code element item per handshake.
`default_nettype none

interface pcd_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] code_value;
  logic       code_valid;

  modport source (output valid, output code_value, output code_valid, input ready);
  modport sink   (input valid, input code_value, input code_valid, output ready);
endinterface

`default_nettype wire

// ===== rtl/pcd_out_if.sv =====
// Output channel: one parent link item per handshake.
`default_nettype none

interface pcd_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] child_node;
  logic [6:0] parent_node;
  logic       error;
  logic       last;

  modport source (output valid, output child_node, output parent_node, output error,
                  output last, input ready);
  modport sink   (input valid, input child_node, input parent_node, input error,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/pcd_ctrl.sv =====
// Controller state machine: sequences loading, decode pass and emission.
`default_nettype none

module pcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcd_pkg::pcd_stat_t stat,
  output pcd_pkg::pcd_cmd_t  cmd
);
  import pcd_pkg::*;

  typedef enum logic [10:0] {
    S_LOAD     = 11'b000_0000_0001,
    S_INC      = 11'b000_0000_0010,
    S_FETCH    = 11'b000_0000_0100,
    S_LEAF     = 11'b000_0000_1000,
    S_SCAN_RD  = 11'b000_0001_0000,
    S_SCAN_CHK = 11'b000_0010_0000,
    S_ASSIGN   = 11'b000_0100_0000,
    S_PAR_UPD  = 11'b000_1000_0000,
    S_EMIT_RD  = 11'b001_0000_0000,
    S_EMIT_OUT = 11'b010_0000_0000,
    S_SINGLE   = 11'b100_0000_0000
  } pcd_state_t;

  pcd_state_t state;
  pcd_state_t state_next;
  logic       fire;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Decode next state and commands
  always_comb begin
    cmd           = '0;
    cmd.seq_clear = cfg_wr;
    state_next    = state;
    in_ready      = (state == S_LOAD);
    fire          = in_valid && in_ready;
    case (state)
      S_LOAD: begin
        if (fire) begin
          if (stat.two_node) begin
            if (!stat.code_flag) begin
              state_next = S_SINGLE;
            end
          end else if (stat.code_flag) begin
            cmd.load_item = 1'b1;
            if (stat.code_ok) begin
              state_next = S_INC;
            end else if (stat.seq_last) begin
              state_next = S_SINGLE;
            end
          end
        end
      end
      S_INC: begin
        cmd.deg_inc = 1'b1;
        if (stat.seq_full) begin
          if (stat.range_err) begin
            state_next = S_SINGLE;
          end else begin
            cmd.dec_init = 1'b1;
            state_next   = S_FETCH;
          end
        end else begin
          state_next = S_LOAD;
        end
      end
      S_FETCH: begin
        cmd.code_rd = 1'b1;
        state_next  = S_LEAF;
      end
      S_LEAF: begin
        state_next = stat.leaf_none ? S_SCAN_RD : S_ASSIGN;
      end
      S_SCAN_RD: begin
        if (stat.ptr_past) begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT_RD;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat.deg_one) begin
          cmd.leaf_set = 1'b1;
          state_next   = S_ASSIGN;
        end else begin
          cmd.scan_step = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_ASSIGN: begin
        cmd.assign_leaf = 1'b1;
        state_next      = S_PAR_UPD;
      end
      S_PAR_UPD: begin
        cmd.par_update = 1'b1;
        if (stat.dec_last) begin
          cmd.emit_init = 1'b1;
          state_next    = S_EMIT_RD;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (stat.emit_last) begin
            cmd.seq_clear = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_SINGLE: begin
        if (stat.out_free) begin
          cmd.single_load = 1'b1;
          cmd.seq_clear   = 1'b1;
          state_next      = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pcd_datapath.sv =====
// Datapath: code store, degree and parent memories, decode registers and output register.
`default_nettype none

module pcd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pcd_pkg::pcd_cmd_t             cmd,
  output pcd_pkg::pcd_stat_t            stat,
  input  logic [pcd_pkg::NODE_W-1:0]    node_count,
  input  logic [pcd_pkg::NODE_W-1:0]    code_value,
  input  logic                          code_valid,
  pcd_out_if.source                     link_out
);
  import pcd_pkg::*;

  // Memories
  logic [NODE_W-1:0]    code_mem [CODE_DEPTH];
  logic [NODE_W-1:0]    deg_mem  [MAX_NODES];
  logic [NODE_W-1:0]    par_mem  [MAX_NODES];
  logic [MAX_NODES-1:0] deg_vld;
  logic [MAX_NODES-1:0] par_vld;

  // Registered read data
  logic [NODE_W-1:0] code_q;
  logic [NODE_W-1:0] deg_q;
  logic              deg_q_vld;
  logic [IDX_W-1:0]  deg_addr_q;
  logic [NODE_W-1:0] par_q;
  logic              par_q_vld;

  // Sequence and decode registers
  logic [CNT_W-1:0]  items;
  logic              range_err;
  logic [NODE_W-1:0] ptr;
  logic [NODE_W-1:0] leaf;
  logic [CNT_W-1:0]  dec_i;
  logic [IDX_W-1:0]  emit_v;

  // Output register
  logic               out_vld;
  logic [CHILD_W-1:0] out_child;
  logic [NODE_W-1:0]  out_parent;
  logic               out_error;
  logic               out_last;

  // Combinational helpers
  logic [NODE_W-1:0] seq_len;
  logic              code_ok;
  logic [NODE_W-1:0] deg_val;
  logic [NODE_W-1:0] deg_dec;
  logic [NODE_W-1:0] deg_incv;
  logic [NODE_W-1:0] leaf_next;
  logic [NODE_W-1:0] par_eff;
  logic              emit_last;
  logic              out_free;
  logic              deg_re;
  logic [IDX_W-1:0]  deg_ra;
  logic              deg_we;
  logic [IDX_W-1:0]  deg_wa;
  logic [NODE_W-1:0] deg_wd;

  assign seq_len   = node_count - NODE_W'(2);
  assign code_ok   = (code_value != '0) && (code_value <= node_count);
  assign deg_val   = deg_q_vld ? deg_q : NODE_W'(1);
  assign deg_dec   = (deg_val != '0) ? deg_val - NODE_W'(1) : '0;
  assign deg_incv  = (deg_val == '1) ? deg_val : deg_val + NODE_W'(1);
  assign leaf_next = ((code_q < ptr) && (deg_dec == NODE_W'(1))) ? code_q : '0;
  assign par_eff   = par_q_vld ? par_q : '0;
  assign emit_last = (NODE_W'(emit_v) == node_count - NODE_W'(1));
  assign out_free  = !out_vld || link_out.ready;

  // Select degree read port
  always_comb begin
    deg_re = 1'b0;
    deg_ra = '0;
    if (cmd.load_item) begin
      deg_re = 1'b1;
      deg_ra = IDX_W'(code_value - NODE_W'(1));
    end else if (cmd.scan_rd) begin
      deg_re = 1'b1;
      deg_ra = IDX_W'(ptr - NODE_W'(1));
    end else if (cmd.assign_leaf) begin
      deg_re = 1'b1;
      deg_ra = IDX_W'(code_q - NODE_W'(1));
    end
  end

  // Select degree write port
  always_comb begin
    deg_we = 1'b0;
    deg_wa = '0;
    deg_wd = '0;
    if (cmd.deg_inc) begin
      deg_we = 1'b1;
      deg_wa = deg_addr_q;
      deg_wd = deg_incv;
    end else if (cmd.assign_leaf) begin
      deg_we = 1'b1;
      deg_wa = IDX_W'(leaf - NODE_W'(1));
      deg_wd = '0;
    end else if (cmd.par_update) begin
      deg_we = 1'b1;
      deg_wa = deg_addr_q;
      deg_wd = deg_dec;
    end
  end

  // Code store: write on load, read during decode
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      code_mem[items[CODE_AW-1:0]] <= code_value;
    end
    if (cmd.code_rd) begin
      code_q <= code_mem[dec_i[CODE_AW-1:0]];
    end
  end

  // Degree memory
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (deg_re) begin
      deg_q      <= deg_mem[deg_ra];
      deg_q_vld  <= deg_vld[deg_ra];
      deg_addr_q <= deg_ra;
    end
  end

  // Parent memory
  always_ff @(posedge clk) begin
    if (cmd.assign_leaf) begin
      par_mem[IDX_W'(leaf - NODE_W'(1))] <= code_q;
    end
    if (cmd.emit_rd) begin
      par_q     <= par_mem[emit_v - IDX_W'(1)];
      par_q_vld <= par_vld[emit_v - IDX_W'(1)];
    end
  end

  // Valid bits: an unwritten degree reads as one, an unwritten parent as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.seq_clear) begin
      deg_vld <= '0;
      par_vld <= '0;
    end else begin
      if (deg_we) begin
        deg_vld[deg_wa] <= 1'b1;
      end
      if (cmd.assign_leaf) begin
        par_vld[IDX_W'(leaf - NODE_W'(1))] <= 1'b1;
      end
    end
  end

  // Count items and flag out-of-range codes
  always_ff @(posedge clk) begin
    if (rst || cmd.seq_clear) begin
      items     <= '0;
      range_err <= 1'b0;
    end else if (cmd.load_item) begin
      items <= items + CNT_W'(1);
      if (!code_ok) begin
        range_err <= 1'b1;
      end
    end
  end

  // Advance pointer, leaf and decode index
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= NODE_W'(1);
      leaf  <= '0;
      dec_i <= '0;
    end else if (cmd.dec_init) begin
      ptr   <= NODE_W'(1);
      leaf  <= '0;
      dec_i <= '0;
    end else begin
      if (cmd.scan_step) begin
        ptr <= ptr + NODE_W'(1);
      end
      if (cmd.leaf_set) begin
        leaf <= ptr;
      end
      if (cmd.par_update) begin
        dec_i <= dec_i + CNT_W'(1);
        leaf  <= leaf_next;
      end
    end
  end

  // Step the emission node
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_v <= IDX_W'(1);
    end else if (cmd.emit_init) begin
      emit_v <= IDX_W'(1);
    end else if (cmd.emit_load) begin
      emit_v <= emit_v + IDX_W'(1);
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.emit_load || cmd.single_load) begin
      out_vld <= 1'b1;
    end else if (link_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_child  <= CHILD_W'(emit_v);
      out_parent <= (par_eff == '0) ? node_count : par_eff;
      out_error  <= 1'b0;
      out_last   <= emit_last;
    end else if (cmd.single_load) begin
      out_child  <= range_err ? CHILD_W'(0) : CHILD_W'(1);
      out_parent <= range_err ? NODE_W'(0) : NODE_W'(2);
      out_error  <= range_err;
      out_last   <= 1'b1;
    end
  end

  assign link_out.valid       = out_vld;
  assign link_out.child_node  = out_child;
  assign link_out.parent_node = out_parent;
  assign link_out.error       = out_error;
  assign link_out.last        = out_last;

  // Status to the controller
  assign stat.two_node  = (seq_len == '0);
  assign stat.code_flag = code_valid;
  assign stat.code_ok   = code_ok;
  assign stat.seq_last  = (NODE_W'(items) + NODE_W'(1) == seq_len);
  assign stat.seq_full  = (NODE_W'(items) == seq_len);
  assign stat.range_err = range_err;
  assign stat.leaf_none = (leaf == '0);
  assign stat.ptr_past  = (ptr > node_count);
  assign stat.deg_one   = (deg_val == NODE_W'(1));
  assign stat.dec_last  = (NODE_W'(dec_i) + NODE_W'(1) == seq_len);
  assign stat.emit_last = emit_last;
  assign stat.out_free  = out_free;

  // An edge item always names a real parent
  a_edge_parent: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |=> out_vld && (out_parent != '0) && !out_error)
    else $error("edge item loaded with zero parent or error set");

  // A sequence restart empties the counters
  a_seq_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.seq_clear |=> (items == '0) && !range_err && (deg_vld == '0))
    else $error("sequence state not cleared");

  // A leaf is never its own parent
  a_leaf_parent: assert property (@(posedge clk) disable iff (rst)
    cmd.assign_leaf |-> (leaf != code_q) && (leaf != '0))
    else $error("leaf equals its parent or is empty");

  // No element is stored past the sequence length
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |-> (NODE_W'(items) < seq_len))
    else $error("code element stored past sequence length");

endmodule

`default_nettype wire

// ===== rtl/prufer_code_decoder_core.sv =====
// Steps: an in-range code item is stored in S_LOAD and its degree raised in S_INC (an out-of-range
// item only in S_LOAD); after the last item each element passes S_FETCH, S_LEAF, a leaf scan of
// S_SCAN_RD/S_SCAN_CHK pairs when no leaf is held (the pointer steps at most up to node_count),
// S_ASSIGN and S_PAR_UPD; then each edge is emitted through S_EMIT_RD and S_EMIT_OUT. One sequence
// at a time; the degree memory read-modify-write paces loading and the scan/emit loops the decode.
// Reset (synchronous, active high): node_count returns to 2 and the block waits for a new sequence.
`default_nettype none

module prufer_code_decoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pcd_pkg::ADDR_W-1:0]    paddr,
  input  logic [pcd_pkg::DATA_W-1:0]    pwdata,
  output logic [pcd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  pcd_in_if.sink                        code_in,
  pcd_out_if.source                     link_out
);
  import pcd_pkg::*;

  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] wr_value;
  logic [NODE_W-1:0] wr_clamped;
  logic              reg_hit;
  logic              cfg_wr;
  pcd_cmd_t          cmd;
  pcd_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_NODE_COUNT);
  assign cfg_wr  = psel && penable && pwrite && reg_hit;

  // Clamp the written node count into range
  always_comb begin
    wr_value = pwdata[NODE_W-1:0];
    if (wr_value < NODE_MIN) begin
      wr_clamped = NODE_MIN;
    end else if (wr_value > NODE_MAX) begin
      wr_clamped = NODE_MAX;
    end else begin
      wr_clamped = wr_value;
    end
  end

  // node_count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_MIN;
    end else if (cfg_wr) begin
      node_count <= wr_clamped;
    end
  end

  assign prdata = reg_hit ? DATA_W'(node_count) : '0;

  pcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (code_in.valid),
    .in_ready (code_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcd_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .node_count (node_count),
    .code_value (code_in.code_value),
    .code_valid (code_in.code_valid),
    .link_out   (link_out)
  );

endmodule

`default_nettype wire

// ===== sim/prufer_code_decoder_core_tb.sv =====
// Testbench for the tree code decoder: random and directed sequences checked by a scoreboard.
`timescale 1ns / 1ps

// Tracks the decoder state and holds the parent links still to come
class link_scoreboard;
  typedef struct packed {
    logic [pcd_pkg::CHILD_W-1:0] child;
    logic [pcd_pkg::NODE_W-1:0]  parent;
    logic                        err;
    logic                        last;
  } link_t;

  int unsigned node_total = 2;
  logic [pcd_pkg::NODE_W-1:0] codes [pcd_pkg::MAX_NODES];
  int unsigned degree [pcd_pkg::MAX_NODES + 2];
  int unsigned parent_of [pcd_pkg::MAX_NODES + 2];
  int unsigned loaded;
  bit bad_code;
  link_t links_due[$];
  int errors;
  int links_seen;
  int trees;
  int error_runs;

  // Return the tables to their sequence-start values
  function void clear_tables();
    foreach (degree[i]) degree[i] = 1;
    foreach (parent_of[i]) parent_of[i] = 0;
    loaded = 0;
    bad_code = 1'b0;
  endfunction

  // Append one link to the tail of the expected queue
  function void queue_link(link_t lk);
    links_due = {links_due, lk};
  endfunction

  // Clamp a node_count write and abandon any partial sequence
  function void set_count(logic [pcd_pkg::DATA_W-1:0] data);
    int unsigned v;
    v = data[pcd_pkg::NODE_W-1:0];
    if (v < 2) v = 2;
    if (v > pcd_pkg::MAX_NODES) v = pcd_pkg::MAX_NODES;
    node_total = v;
    clear_tables();
  endfunction

  // Linear decode pass, then queue one link per non-root node
  function void build_links();
    int unsigned n;
    int unsigned ptr;
    int unsigned leaf;
    int unsigned par;
    int unsigned p;
    link_t lk;
    n = node_total;
    ptr = 1;
    leaf = 0;
    for (int i = 0; i < n - 2; i++) begin
      par = codes[i];
      if (par < 1 || par > n) break;
      if (leaf == 0) begin
        while (ptr <= n && degree[ptr] != 1) ptr++;
        if (ptr > n) break;
        leaf = ptr;
      end
      parent_of[leaf] = par;
      if (degree[leaf] > 0) degree[leaf]--;
      if (degree[par] > 0) degree[par]--;
      // a parent that drops to a leaf below the pointer goes next
      if (par < ptr && degree[par] == 1) leaf = par;
      else leaf = 0;
    end
    for (int v = 1; v < n; v++) begin
      p = (parent_of[v] == 0) ? n : parent_of[v];
      lk.child = v[pcd_pkg::CHILD_W-1:0];
      lk.parent = p[pcd_pkg::NODE_W-1:0];
      lk.err = 1'b0;
      lk.last = (v == n - 1);
      queue_link(lk);
    end
    trees++;
  endfunction

  // Account for one accepted input item
  function void note_code(logic [pcd_pkg::NODE_W-1:0] value, logic flag);
    int unsigned len;
    link_t lk;
    len = node_total - 2;
    if (len == 0) begin
      if (!flag) begin
        lk = '{child: 1, parent: 2, err: 1'b0, last: 1'b1};
        queue_link(lk);
        trees++;
        clear_tables();
      end
      return;
    end
    if (!flag) return;
    if (loaded < len) begin
      codes[loaded] = value;
      if (value < 1 || value > node_total) bad_code = 1'b1;
      else if (degree[value] < 127) degree[value]++;
      loaded++;
    end
    if (loaded < len) return;
    if (bad_code) begin
      lk = '{child: 0, parent: 0, err: 1'b1, last: 1'b1};
      queue_link(lk);
      error_runs++;
    end else begin
      build_links();
    end
    clear_tables();
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare one accepted link with the oldest one due
  function void check_link(logic [pcd_pkg::CHILD_W-1:0] child,
                           logic [pcd_pkg::NODE_W-1:0] parent, logic err, logic last);
    link_t due;
    links_seen++;
    if (links_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected link: expected none, actual child %0d parent %0d error %0b last %0b",
               $time, child, parent, err, last);
      return;
    end
    due = links_due.pop_front();
    compare_field("child_node", 8'(due.child), 8'(child));
    compare_field("parent_node", 8'(due.parent), 8'(parent));
    compare_field("error", 8'(due.err), 8'(err));
    compare_field("last", 8'(due.last), 8'(last));
  endfunction

  function int pending();
    return links_due.size();
  endfunction
endclass

module prufer_code_decoder_core_tb;
  import pcd_pkg::*;

  localparam int ITEM_GOAL   = 420;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE      = 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pcd_in_if  code_ch ();
  pcd_out_if link_ch ();

  link_scoreboard sb;
  bit steady;
  bit start_hold;
  int items_sent;
  int writes_done;

  prufer_code_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .code_in  (code_ch),
    .link_out (link_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Take links, stall at random, hold off for a long stretch on request
  initial begin : link_sink
    int hold_left;
    hold_left = 0;
    link_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && link_ch.valid && link_ch.ready)
        sb.check_link(link_ch.child_node, link_ch.parent_node, link_ch.error, link_ch.last);
      if (start_hold) begin
        hold_left = HOLD_CYCLES;
        start_hold = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        link_ch.ready <= 1'b0;
      end else begin
        link_ch.ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  // Offer one item, with a random gap ahead of it, and wait for acceptance
  task automatic send_item(input logic [NODE_W-1:0] value, input logic flag);
    while (!steady && $urandom_range(99) < 6) begin
      code_ch.valid <= 1'b0;
      @(posedge clk);
    end
    code_ch.valid <= 1'b1;
    code_ch.code_value <= value;
    code_ch.code_valid <= flag;
    do @(posedge clk); while (!code_ch.ready);
    if ((sb.node_total == 2) != flag) items_sent++;
    sb.note_code(value, flag);
  endtask

  // Drop valid, drain all links, then let the block finish any load in flight
  task automatic settle();
    code_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write node_count while the block is idle
  task automatic write_count(input logic [DATA_W-1:0] data);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_NODE_COUNT, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_count(data);
    writes_done++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One full sequence for an n-node tree, with stray no-code items mixed in
  task automatic send_tree(input int n, input bit faulty);
    int len;
    int bad_at;
    bit narrow;
    logic [NODE_W-1:0] v;
    len = n - 2;
    narrow = ($urandom_range(3) == 0);
    bad_at = faulty ? int'($urandom_range(len - 1)) : -1;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) send_item(NODE_W'($urandom), 1'b0);
      if (k == bad_at)
        v = $urandom_range(1) ? '0 : NODE_W'($urandom_range(127, n + 1));
      else if (narrow)
        v = NODE_W'($urandom_range(3, 1));
      else
        v = NODE_W'($urandom_range(n, 1));
      send_item(v, 1'b1);
    end
  endtask

  initial begin : stimulus
    int phase;
    int r;
    int seqs;
    int n;
    logic [DATA_W-1:0] data;

    sb = new();
    sb.clear_tables();
    steady = 1'b0;
    start_hold = 1'b0;
    items_sent = 0;
    writes_done = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    code_ch.valid <= 1'b0;
    code_ch.code_value <= '0;
    code_ch.code_valid <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two-node tree: a code item is ignored, a no-code item emits the single link
    write_count(0);
    send_item(7'h7F, 1'b1);
    send_item(7'h00, 1'b0);
    write_count(1);
    send_item(7'h55, 1'b0);

    // Three nodes: each legal element, then below, far above and just above range
    write_count(3);
    send_item(3, 1'b1);
    send_item(1, 1'b1);
    send_item(2, 1'b1);
    send_item(0, 1'b1);
    send_item(7'h7F, 1'b1);
    send_item(4, 1'b1);
    send_item(5, 1'b0);

    // Four nodes: star, two bad elements giving one error, then a path
    write_count(4);
    send_item(4, 1'b1);
    send_item(4, 1'b1);
    send_item(0, 1'b1);
    send_item(7'h7F, 1'b1);
    send_item(1, 1'b1);
    send_item(4, 1'b1);

    // Abandon a partial sequence with a register write, then load a fresh one
    write_count(5);
    send_item(2, 1'b1);
    send_item(3, 1'b1);
    write_count(5);
    send_item(5, 1'b1);
    send_item(5, 1'b1);
    send_item(1, 1'b1);

    // Random phases: a node_count per phase, several sequences under it
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      r = $urandom_range(99);
      if (phase == 0) data = 64;
      else if (phase == 1) data = 127;
      else if (phase == 2) data = 7;
      else if (r < 8) data = 2;
      else if (r < 14) data = 64;
      else if (r < 20) data = $urandom_range(1) ? $urandom_range(1) : $urandom_range(127, 65);
      else if (r < 30) data = $urandom_range(40, 13);
      else data = $urandom_range(12, 3);
      if ($urandom_range(3) == 0) data = data | ($urandom & ~32'h7F);
      write_count(data);
      n = sb.node_total;
      steady = (phase == 4 || phase == 5);
      if (phase == 2) start_hold = 1'b1;
      if (n >= 40) seqs = 1;
      else if (phase == 2) seqs = 5;
      else seqs = $urandom_range(5, 2);
      repeat (seqs) begin
        if (n == 2) send_item(NODE_W'($urandom), $urandom_range(4) == 0);
        else send_tree(n, $urandom_range(9) == 0);
      end
      phase++;
    end

    // Drain and allow for any stray late link
    steady = 1'b0;
    code_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d code items over %0d register writes and %0d random phases.",
             items_sent, writes_done, phase);
    $display("Checked %0d links: %0d trees decoded, %0d error results.",
             sb.links_seen, sb.trees, sb.error_runs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
